### rtl/core/tsc_pkg.sv
// Shared types and constants for the text frame sync and checksum block.
package tsc_pkg;

   localparam int TMO_W  = 16;
   localparam int LEN_W  = 10;
   localparam int POS_W  = 9;
   localparam int KIND_W = 3;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [KIND_W-1:0] K_BYTE    = 3'd0;
   localparam logic [KIND_W-1:0] K_RESTART = 3'd1;
   localparam logic [KIND_W-1:0] K_GOOD    = 3'd2;
   localparam logic [KIND_W-1:0] K_BAD     = 3'd3;
   localparam logic [KIND_W-1:0] K_OVERRUN = 3'd4;
   localparam logic [KIND_W-1:0] K_TIMEOUT = 3'd5;

   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_P  = 8'h50;
   localparam logic [7:0] CH_I  = 8'h49;
   localparam logic [7:0] CH_D  = 8'h44;

   localparam logic [23:0] PID_TAG   = 24'h504944;
   localparam logic [63:0] END_LABEL = 64'h436865636b73756d;

   // sums of CR LF P I and CR LF P I D
   localparam logic [7:0] SUM4 = 8'hb0;
   localparam logic [7:0] SUM5 = 8'hf4;

   localparam logic [TMO_W-1:0] TMO_RESET = 16'd1500;
   localparam logic [LEN_W-1:0] MAX_RESET = 10'd512;

   localparam logic [2:0] ADDR_W = 3'd3;

   typedef struct packed {
      logic                start;
      logic                byte_v;
      logic [7:0]          data;
      logic [POS_W-1:0]    pos;
      logic                restart;
      logic                status_v;
      logic [KIND_W-1:0]   status_kind;
      logic [POS_W-1:0]    status_pos;
   } tsc_evt_type;

   function automatic logic [7:0] start_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = CH_CR;
         2'd1: b = CH_LF;
         2'd2: b = CH_P;
         default: b = CH_I;
      endcase
      return b;
   endfunction

endpackage

### rtl/core/tsc_front.sv
// Front end: start hunt, frame tracking, checksum and timeout classification.
module tsc_front #(
   parameter int BUFFER_BYTES = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             op,
   input  logic [7:0]                       rx_byte,
   input  logic [tsc_pkg::TMO_W-1:0]        timeout_ticks,
   input  logic [tsc_pkg::LEN_W-1:0]        max_frame_len,
   output logic                             evt_push,
   output tsc_pkg::tsc_evt_type             evt
);

   localparam int BUF_W = $clog2(BUFFER_BYTES + 1);
   localparam int LIM_W = (BUF_W > tsc_pkg::LEN_W) ? BUF_W : tsc_pkg::LEN_W;
   localparam logic [LIM_W-1:0] BUF_LIM = LIM_W'(BUFFER_BYTES);

   localparam logic [2:0] PH_CR  = 3'd0;
   localparam logic [2:0] PH_LF  = 3'd1;
   localparam logic [2:0] PH_P   = 3'd2;
   localparam logic [2:0] PH_I   = 3'd3;
   localparam logic [2:0] PH_COL = 3'd4;

   logic [2:0]                  phase_ff, phase_in;
   logic [tsc_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [7:0]                  sum_ff, sum_in;
   logic [79:0]                 rec_ff, rec_in;
   logic [tsc_pkg::TMO_W-1:0]   elap_ff, elap_in;

   logic [tsc_pkg::TMO_W:0]     tick_t;
   logic [tsc_pkg::LEN_W-1:0]   new_len, aft_len, last_len, aft_last;
   logic [79:0]                 new_rec, aft_rec;
   logic [7:0]                  new_sum, aft_sum;
   logic                        pid_hit, end_hit, ovr;
   logic [LIM_W-1:0]            limit;

   assign tick_t   = {1'b0, elap_ff} + {{tsc_pkg::TMO_W{1'b0}}, 1'b1};
   assign new_len  = len_ff + 10'd1;
   assign last_len = len_ff - 10'd1;
   assign new_rec  = {rec_ff[71:0], rx_byte};
   assign new_sum  = sum_ff + rx_byte;
   assign pid_hit  = (new_len > 10'd5) && (new_rec[23:0] == tsc_pkg::PID_TAG);
   assign aft_len  = pid_hit ? 10'd5 : new_len;
   assign aft_last = aft_len - 10'd1;
   assign aft_sum  = pid_hit ? tsc_pkg::SUM5 : new_sum;
   assign aft_rec  = pid_hit ? {40'd0, tsc_pkg::CH_CR, tsc_pkg::CH_LF, tsc_pkg::CH_P,
                                tsc_pkg::CH_I, tsc_pkg::CH_D} : new_rec;
   assign end_hit  = !pid_hit && (new_len > 10'd10) &&
                     (new_rec[79:16] == tsc_pkg::END_LABEL);
   assign limit    = (LIM_W'(max_frame_len) < BUF_LIM) ? LIM_W'(max_frame_len) : BUF_LIM;
   assign ovr      = LIM_W'(aft_len) >= limit;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      rec_in   = rec_ff;
      elap_in  = elap_ff;
      evt      = '0;
      evt_push = 1'b0;
      if (accept) begin
         if (op) begin
            if ((phase_ff == PH_COL) ? (tick_t >= {1'b0, timeout_ticks})
                                     : (tick_t > {1'b0, timeout_ticks})) begin
               evt_push         = 1'b1;
               evt.status_v     = 1'b1;
               evt.status_kind  = tsc_pkg::K_TIMEOUT;
               evt.status_pos   = (phase_ff == PH_COL) ? last_len[tsc_pkg::POS_W-1:0]
                                                       : '0;
               phase_in = PH_CR;
               len_in   = '0;
               sum_in   = '0;
               rec_in   = '0;
               elap_in  = '0;
            end else begin
               elap_in = tick_t[tsc_pkg::TMO_W-1:0];
            end
         end else begin
            case (phase_ff)
               PH_CR: begin
                  if (rx_byte == tsc_pkg::CH_CR) phase_in = PH_LF;
               end
               PH_LF: begin
                  phase_in = (rx_byte == tsc_pkg::CH_LF) ? PH_P : PH_CR;
               end
               PH_P: begin
                  phase_in = (rx_byte == tsc_pkg::CH_P) ? PH_I : PH_CR;
               end
               PH_I: begin
                  if (rx_byte == tsc_pkg::CH_I) begin
                     evt_push  = 1'b1;
                     evt.start = 1'b1;
                     phase_in  = PH_COL;
                     len_in    = 10'd4;
                     sum_in    = tsc_pkg::SUM4;
                     rec_in    = {48'd0, tsc_pkg::CH_CR, tsc_pkg::CH_LF, tsc_pkg::CH_P,
                                  tsc_pkg::CH_I};
                     elap_in   = '0;
                  end else begin
                     phase_in = PH_CR;
                  end
               end
               PH_COL: begin
                  evt_push    = 1'b1;
                  evt.byte_v  = 1'b1;
                  evt.data    = rx_byte;
                  evt.pos     = len_ff[tsc_pkg::POS_W-1:0];
                  evt.restart = pid_hit;
                  if (ovr || end_hit) begin
                     evt.status_v    = 1'b1;
                     evt.status_kind = ovr ? tsc_pkg::K_OVERRUN :
                                       ((aft_sum == 8'd0) ? tsc_pkg::K_GOOD : tsc_pkg::K_BAD);
                     evt.status_pos  = aft_last[tsc_pkg::POS_W-1:0];
                     phase_in = PH_CR;
                     len_in   = '0;
                     sum_in   = '0;
                     rec_in   = '0;
                     elap_in  = '0;
                  end else begin
                     len_in = aft_len;
                     sum_in = aft_sum;
                     rec_in = aft_rec;
                  end
               end
               default: begin
                  phase_in = PH_CR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CR;
         len_ff   <= '0;
         sum_ff   <= '0;
         rec_ff   <= '0;
         elap_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         rec_ff   <= rec_in;
         elap_ff  <= elap_in;
      end
   end

endmodule

### rtl/core/tsc_queue.sv
// Short event queue between front and back ends.
module tsc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tsc_pkg::tsc_evt_type  push_data,
   input  logic                  pop,
   output tsc_pkg::tsc_evt_type  pop_data,
   output logic                  empty,
   output logic                  full
);

   tsc_pkg::tsc_evt_type            mem_ff [tsc_pkg::QDEPTH];
   logic [tsc_pkg::QPTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [tsc_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == tsc_pkg::QCNT_W'(tsc_pkg::QDEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 3'd1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/tsc_back.sv
// Back end: expands queued events into result transfers through an output register.
module tsc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  tsc_pkg::tsc_evt_type         q_data,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [tsc_pkg::KIND_W-1:0]   rsp_kind,
   output logic [7:0]                   rsp_frame_byte,
   output logic [tsc_pkg::POS_W-1:0]    rsp_position,
   output logic                         rsp_last_of_run
);

   tsc_pkg::tsc_evt_type            cur_ff, cur_in;
   logic [3:0]                      pend_ff, pend_in;   // status, restart, byte, start
   logic [1:0]                      stp_ff, stp_in;
   logic                            ov_ff, ov_in;
   logic [tsc_pkg::KIND_W-1:0]      okind_ff, okind_in;
   logic [7:0]                      obyte_ff, obyte_in;
   logic [tsc_pkg::POS_W-1:0]       opos_ff, opos_in;
   logic                            olast_ff, olast_in;

   logic                            act, emit, last;
   logic [tsc_pkg::KIND_W-1:0]      r_kind;
   logic [7:0]                      r_byte;
   logic [tsc_pkg::POS_W-1:0]       r_pos;
   logic [3:0]                      pend_nx;

   assign act  = |pend_ff;
   assign emit = act && (!ov_ff || rsp_pop);

   always_comb begin
      r_kind  = tsc_pkg::K_BYTE;
      r_byte  = '0;
      r_pos   = '0;
      last    = 1'b0;
      pend_nx = pend_ff;
      if (pend_ff[0]) begin
         r_byte = tsc_pkg::start_byte(stp_ff);
         r_pos  = tsc_pkg::POS_W'(stp_ff);
         last   = (stp_ff == 2'd3);
         if (last) pend_nx[0] = 1'b0;
      end else if (pend_ff[1]) begin
         r_byte     = cur_ff.data;
         r_pos      = cur_ff.pos;
         last       = !pend_ff[2] && !pend_ff[3];
         pend_nx[1] = 1'b0;
      end else if (pend_ff[2]) begin
         r_kind     = tsc_pkg::K_RESTART;
         r_pos      = 9'd4;
         last       = !pend_ff[3];
         pend_nx[2] = 1'b0;
      end else begin
         r_kind     = cur_ff.status_kind;
         r_pos      = cur_ff.status_pos;
         last       = 1'b1;
         pend_nx[3] = 1'b0;
      end
   end

   assign q_pop = (!act || (emit && last)) && !q_empty;

   always_comb begin
      cur_in   = cur_ff;
      pend_in  = pend_ff;
      stp_in   = stp_ff;
      ov_in    = ov_ff;
      okind_in = okind_ff;
      obyte_in = obyte_ff;
      opos_in  = opos_ff;
      olast_in = olast_ff;
      if (emit) begin
         pend_in  = pend_nx;
         stp_in   = stp_ff + 2'd1;
         ov_in    = 1'b1;
         okind_in = r_kind;
         obyte_in = r_byte;
         opos_in  = r_pos;
         olast_in = last;
      end else if (rsp_pop) begin
         ov_in = 1'b0;
      end
      if (q_pop) begin
         cur_in  = q_data;
         pend_in = {q_data.status_v, q_data.restart, q_data.byte_v, q_data.start};
         stp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         stp_ff  <= '0;
         ov_ff   <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         stp_ff  <= stp_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      okind_ff <= okind_in;
      obyte_ff <= obyte_in;
      opos_ff  <= opos_in;
      olast_ff <= olast_in;
   end

   assign rsp_empty       = !ov_ff;
   assign rsp_kind        = okind_ff;
   assign rsp_frame_byte  = obyte_ff;
   assign rsp_position    = opos_ff;
   assign rsp_last_of_run = olast_ff;

endmodule

### rtl/core/text_frame_sync_checksum.sv
// Top level: register port, front end, event queue and back end.
// Throughput: one item per cycle while the event queue is not full; the back end
// sends one result per cycle while the result channel is not stalled, so a start
// match (four results) holds it while later events wait in a 4-entry queue.
// Reset is synchronous: hunting for CR, frame state cleared, registers to defaults.
module text_frame_sync_checksum #(
   parameter int BUFFER_BYTES = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_op,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [tsc_pkg::KIND_W-1:0]      rsp_kind,
   output logic [7:0]                      rsp_frame_byte,
   output logic [tsc_pkg::POS_W-1:0]       rsp_position,
   output logic                            rsp_last_of_run,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tsc_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [tsc_pkg::TMO_W-1:0]   tmo_ff, tmo_in;
   logic [tsc_pkg::LEN_W-1:0]   max_ff, max_in;
   logic                        wr_en, accept, evt_push, q_pop, q_empty;
   tsc_pkg::tsc_evt_type        evt, q_data;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? {22'd0, max_ff} : {16'd0, tmo_ff};

   always_comb begin
      tmo_in = tmo_ff;
      max_in = max_ff;
      if (wr_en) begin
         if (csr_paddr[2]) max_in = csr_pwdata[tsc_pkg::LEN_W-1:0];
         else              tmo_in = csr_pwdata[tsc_pkg::TMO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff <= tsc_pkg::TMO_RESET;
         max_ff <= tsc_pkg::MAX_RESET;
      end else begin
         tmo_ff <= tmo_in;
         max_ff <= max_in;
      end
   end

   assign accept = req_push && !req_full;

   tsc_front #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_op),
      .rx_byte       (req_rx_byte),
      .timeout_ticks (tmo_ff),
      .max_frame_len (max_ff),
      .evt_push      (evt_push),
      .evt           (evt)
   );

   tsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (req_full)
   );

   tsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_position    (rsp_position),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### rtl/core/tsc_checker.sv
// Port-level checker for the result channel, bound to the top level.
module tsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [tsc_pkg::KIND_W-1:0]    rsp_kind,
   input logic [7:0]                    rsp_frame_byte,
   input logic [tsc_pkg::POS_W-1:0]     rsp_position
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_kind <= tsc_pkg::K_TIMEOUT))
      else $error("result kind out of range");

   a_status_no_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != tsc_pkg::K_BYTE) |-> (rsp_frame_byte == 8'd0))
      else $error("status transfer carries a frame byte");

   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == tsc_pkg::K_RESTART) |-> (rsp_position == 9'd4))
      else $error("restart transfer not at index four");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
      (!rsp_empty && $stable(rsp_kind) && $stable(rsp_frame_byte) && $stable(rsp_position)))
      else $error("stalled result changed");

endmodule

bind text_frame_sync_checksum tsc_checker u_tsc_checker (.*);

### tb/sv/tb_text_frame_sync_checksum.sv
// Testbench for text_frame_sync_checksum: byte and tick streams checked by a frame predictor.
module tb_text_frame_sync_checksum;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [tsc_pkg::ADDR_W-1:0] REG_TIMEOUT = 3'd0;
   localparam logic [tsc_pkg::ADDR_W-1:0] REG_MAX_LEN = 3'd4;

   localparam int BUF_BYTES      = 512;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [39:0] START_SEQ = {tsc_pkg::CH_D, tsc_pkg::CH_I, tsc_pkg::CH_P,
                                        tsc_pkg::CH_LF, tsc_pkg::CH_CR};

   typedef enum logic [2:0] {HUNT_CR, HUNT_LF, HUNT_P, HUNT_I, COLLECT} sync_state_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } rx_item_type;

   typedef struct packed {
      logic [tsc_pkg::KIND_W-1:0] kind;
      logic [7:0]                 fbyte;
      logic [tsc_pkg::POS_W-1:0]  pos;
      logic                       last;
   } frame_result_type;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic req_push    = 1'b0;
   logic req_op      = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_pop     = 1'b0;
   logic csr_psel    = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite  = 1'b0;
   logic [tsc_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;

   logic                       req_full;
   logic                       rsp_empty;
   logic [tsc_pkg::KIND_W-1:0] rsp_kind;
   logic [7:0]                 rsp_frame_byte;
   logic [tsc_pkg::POS_W-1:0]  rsp_position;
   logic                       rsp_last_of_run;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   rx_item_type      rx_stream[$];
   frame_result_type awaited_frame_results[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;
   int items_queued  = 0;

   // predictor state and register copies
   sync_state_type sync_state;
   logic [9:0]  frame_len;
   logic [7:0]  frame_sum;
   logic [7:0]  tail [10];   // [0] newest
   logic [15:0] tick_count;
   logic [15:0] timeout_cfg = tsc_pkg::TMO_RESET;
   logic [9:0]  max_len_cfg = tsc_pkg::MAX_RESET;

   always #4 clock = ~clock;

   text_frame_sync_checksum dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_rx_byte    (req_rx_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_position   (rsp_position),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   function automatic void clear_frame();
      sync_state = HUNT_CR;
      frame_len  = '0;
      frame_sum  = '0;
      tick_count = '0;
      foreach (tail[i]) tail[i] = '0;
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      for (int i = 9; i > 0; i--) tail[i] = tail[i-1];
      tail[0]   = b;
      frame_sum = frame_sum + b;
      frame_len = frame_len + 1'b1;
   endfunction

   function automatic void reload_start(input int count);
      foreach (tail[i]) tail[i] = '0;
      frame_sum = '0;
      frame_len = '0;
      for (int i = 0; i < count; i++) take_byte(START_SEQ[8*i +: 8]);
   endfunction

   function automatic logic [tsc_pkg::POS_W-1:0] end_pos();
      return (frame_len == '0) ? '0 : frame_len[tsc_pkg::POS_W-1:0] - 1'b1;
   endfunction

   function automatic frame_result_type result_of(input logic [tsc_pkg::KIND_W-1:0] kind,
                                                  input logic [7:0] b,
                                                  input logic [tsc_pkg::POS_W-1:0] pos);
      frame_result_type r;
      r.kind  = kind;
      r.fbyte = b;
      r.pos   = pos;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic void track_frame(input logic op, input logic [7:0] b);
      frame_result_type run [4];
      int   n;
      int   t;
      int   limit;
      logic ended;
      logic expired;
      n = 0;
      if (op == OP_TICK) begin
         t = int'(tick_count) + 1;
         expired = (sync_state == COLLECT) ? (t >= int'(timeout_cfg))
                                           : (t > int'(timeout_cfg));
         if (expired) begin
            run[n] = result_of(tsc_pkg::K_TIMEOUT, 8'h00, end_pos());
            n++;
            clear_frame();
         end else begin
            tick_count = t[15:0];
         end
      end else begin
         case (sync_state)
            HUNT_CR: if (b == tsc_pkg::CH_CR) sync_state = HUNT_LF;
            HUNT_LF: sync_state = (b == tsc_pkg::CH_LF) ? HUNT_P : HUNT_CR;
            HUNT_P:  sync_state = (b == tsc_pkg::CH_P) ? HUNT_I : HUNT_CR;
            HUNT_I: begin
               if (b == tsc_pkg::CH_I) begin
                  for (int i = 0; i < 4; i++) begin
                     run[n] = result_of(tsc_pkg::K_BYTE, START_SEQ[8*i +: 8],
                                        tsc_pkg::POS_W'(i));
                     n++;
                  end
                  reload_start(4);
                  tick_count = '0;
                  sync_state = COLLECT;
               end else begin
                  sync_state = HUNT_CR;
               end
            end
            COLLECT: begin
               limit = (int'(max_len_cfg) < BUF_BYTES) ? int'(max_len_cfg) : BUF_BYTES;
               take_byte(b);
               run[n] = result_of(tsc_pkg::K_BYTE, b, end_pos());
               n++;
               if (frame_len > 10'd5 && {tail[2], tail[1], tail[0]} == tsc_pkg::PID_TAG) begin
                  reload_start(5);
                  run[n] = result_of(tsc_pkg::K_RESTART, 8'h00, 9'd4);
                  n++;
               end
               ended = (frame_len > 10'd10) &&
                       ({tail[9], tail[8], tail[7], tail[6],
                         tail[5], tail[4], tail[3], tail[2]} == tsc_pkg::END_LABEL);
               if (int'(frame_len) >= limit) begin
                  run[n] = result_of(tsc_pkg::K_OVERRUN, 8'h00, end_pos());
                  n++;
                  clear_frame();
               end else if (ended) begin
                  run[n] = result_of((frame_sum == 8'h00) ? tsc_pkg::K_GOOD : tsc_pkg::K_BAD,
                                     8'h00, end_pos());
                  n++;
                  clear_frame();
               end
            end
            default: sync_state = HUNT_CR;
         endcase
      end
      for (int i = 0; i < n; i++) begin
         run[i].last = (i == n - 1);
         awaited_frame_results.push_back(run[i]);
      end
   endfunction

   // driver
   always @(posedge clock) begin : driver
      rx_item_type item;
      if (reset) begin
         req_push <= 1'b0;
         clear_frame();
      end else begin
         if (req_push && !req_full) track_frame(req_op, req_rx_byte);
         if (!req_push || !req_full) begin
            if (rx_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               item = rx_stream.pop_front();
               req_push    <= 1'b1;
               req_op      <= item.op;
               req_rx_byte <= item.data;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      frame_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (awaited_frame_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d byte %02h pos %0d last %0b",
                           rsp_kind, rsp_frame_byte, rsp_position, rsp_last_of_run);
            end else begin
               want = awaited_frame_results.pop_front();
               if (rsp_kind !== want.kind || rsp_frame_byte !== want.fbyte ||
                   rsp_position !== want.pos || rsp_last_of_run !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected kind %0d byte %02h pos %0d last %0b, ",
                               "got %0d %02h %0d %0b"},
                              want.kind, want.fbyte, want.pos, want.last,
                              rsp_kind, rsp_frame_byte, rsp_position, rsp_last_of_run);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("text_frame_sync_checksum regression: fail");
         $finish;
      end
   end

   task automatic write_reg(input logic [tsc_pkg::ADDR_W-1:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == REG_TIMEOUT)
         timeout_cfg = value[15:0];
      else if (addr == REG_MAX_LEN)
         max_len_cfg = value[9:0];
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (rx_stream.size() != 0 || req_push || awaited_frame_results.size() != 0);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_item(input logic op, input logic [7:0] b);
      rx_stream.push_back(rx_item_type'{op, b});
      items_queued++;
   endtask

   task automatic queue_tick();
      queue_item(OP_TICK, 8'($urandom_range(255)));
   endtask

   task automatic queue_start(input int count);
      for (int i = 0; i < count; i++) queue_item(OP_BYTE, START_SEQ[8*i +: 8]);
   endtask

   task automatic queue_frame(input int body_len, input bit with_pid, input bit good,
                              input int tick_pct);
      logic [7:0] sum;
      logic [7:0] b;
      int         pid_at;
      sum    = START_SEQ[7:0] + START_SEQ[15:8] + START_SEQ[23:16] + START_SEQ[31:24];
      pid_at = with_pid ? int'($urandom_range(body_len)) : -1;
      queue_start(4);
      for (int i = 0; i <= body_len; i++) begin
         if (i == pid_at) begin
            queue_item(OP_BYTE, tsc_pkg::CH_P);
            queue_item(OP_BYTE, tsc_pkg::CH_I);
            queue_item(OP_BYTE, tsc_pkg::CH_D);
            sum = tsc_pkg::SUM5;
         end
         if (i < body_len) begin
            b = 8'($urandom_range(255));
            queue_item(OP_BYTE, b);
            sum = sum + b;
         end
         if ($urandom_range(99) < tick_pct) queue_tick();
      end
      for (int i = 0; i < 8; i++) begin
         b = tsc_pkg::END_LABEL[63-8*i -: 8];
         queue_item(OP_BYTE, b);
         sum = sum + b;
      end
      b = 8'($urandom_range(255));
      queue_item(OP_BYTE, b);
      sum = sum + b;
      b = 8'h00 - sum;
      if (!good) b = b + 8'($urandom_range(1, 255));
      queue_item(OP_BYTE, b);
   endtask

   task automatic queue_random_traffic(input int target, input int tick_pct);
      int goal;
      goal = items_queued + target;
      while (items_queued < goal) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6:
               queue_frame(($urandom_range(4) == 0) ? int'($urandom_range(4, 14))
                                                    : int'($urandom_range(0, 3)),
                           $urandom_range(3) == 0, $urandom_range(3) != 0, tick_pct);
            7: begin
               // start sequence cut short
               queue_start($urandom_range(1, 3));
               queue_item(OP_BYTE, 8'($urandom_range(255)));
            end
            8: begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(3) == 0) queue_tick();
                  else queue_item(OP_BYTE, 8'($urandom_range(255)));
               end
            end
            default: repeat ($urandom_range(1, 4)) queue_tick();
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_item(OP_BYTE, 8'h00);
      queue_item(OP_BYTE, 8'hff);
      settle();

      // zero timeout, limit below the start sequence
      write_reg(REG_TIMEOUT, 32'd0);
      write_reg(REG_MAX_LEN, 32'd0);
      queue_tick();
      queue_start(4);
      queue_tick();
      queue_start(4);
      queue_item(OP_BYTE, 8'hff);
      settle();

      write_reg(REG_TIMEOUT, 32'hffff);
      write_reg(REG_MAX_LEN, 32'd1023);
      queue_start(4);
      queue_tick();
      queue_tick();
      settle();
      // timeout lowered under the running count of an open frame, then hunt timeout
      write_reg(REG_TIMEOUT, 32'd1);
      queue_tick();
      queue_tick();
      queue_tick();
      settle();

      write_reg(REG_TIMEOUT, 32'hffff);
      queue_frame(20, 1'b0, 1'b1, 0);
      queue_random_traffic(30, 5);
      settle();

      send_idle_pct = 54;
      write_reg(REG_TIMEOUT, 32'd1);
      write_reg(REG_MAX_LEN, 32'd16);
      queue_random_traffic(40, 3);
      settle();

      send_idle_pct = 0;
      rsp_stall_pct = 54;
      write_reg(REG_TIMEOUT, 32'($urandom_range(5, 30)));
      write_reg(REG_MAX_LEN, 32'd512);
      queue_random_traffic(20, 5);
      wait_drained();
      queue_random_traffic(20, 5);
      settle();

      send_idle_pct = 38;
      rsp_stall_pct = 38;
      write_reg(REG_TIMEOUT, 32'd1500);
      write_reg(REG_MAX_LEN, 32'($urandom_range(17, 40)));
      queue_random_traffic(40, 5);
      settle();

      if (mismatches == 0 && awaited_frame_results.size() == 0)
         $display("text_frame_sync_checksum regression: pass");
      else
         $display("text_frame_sync_checksum regression: fail");
      $finish;
   end

endmodule
